// ===== src/bcpm_pkg.sv =====
package bcpm_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] mem_address;
      logic [7:0]  mem_data;
      logic        serial_in_bit;
      logic [7:0]  parallel_in;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_out;
      logic [15:0] code_address;
      logic [7:0]  acc_out;
      logic [7:0]  offset_out;
      logic [7:0]  data_page_out;
      logic [7:0]  inner_out;
      logic [7:0]  local_page_out;
      logic        sclk_out;
      logic        mosi_out;
      logic [7:0]  parallel_out;
      logic [7:0]  enable_out;
      logic [7:0]  scrounge_out;
   } rsp_type;

   localparam logic [1:0] KIND_EXEC   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // PAIR sources
   localparam logic [2:0] SRC_LIT   = 3'd0;
   localparam logic [2:0] SRC_DMEM  = 3'd1;
   localparam logic [2:0] SRC_LMEM  = 3'd2;
   localparam logic [2:0] SRC_DPAGE = 3'd3;
   localparam logic [2:0] SRC_ACC   = 3'd4;
   localparam logic [2:0] SRC_INNER = 3'd5;
   localparam logic [2:0] SRC_SIN   = 3'd6;

   // PAIR destinations
   localparam logic [3:0] DST_OFFSET = 4'd0;
   localparam logic [3:0] DST_DMEM   = 4'd1;
   localparam logic [3:0] DST_LMEM   = 4'd2;
   localparam logic [3:0] DST_DPAGE  = 4'd3;
   localparam logic [3:0] DST_ACC    = 4'd4;
   localparam logic [3:0] DST_INNER  = 4'd5;
   localparam logic [3:0] DST_SOUT   = 4'd6;
   localparam logic [3:0] DST_POUT   = 4'd7;
   localparam logic [3:0] DST_ENABLE = 4'd8;
   localparam logic [3:0] DST_ADDOFS = 4'd9;
   localparam logic [3:0] DST_JREL   = 4'd10;
   localparam logic [3:0] DST_JMP    = 4'd11;
   localparam logic [3:0] DST_LOOP   = 4'd12;
   localparam logic [3:0] DST_JNZ    = 4'd13;
   localparam logic [3:0] DST_JZ     = 4'd14;
   localparam logic [3:0] DST_CALL   = 4'd15;

   // DIRO register select
   localparam logic [1:0] DR_DPAGE = 2'd0;
   localparam logic [1:0] DR_INNER = 2'd1;
   localparam logic [1:0] DR_ACC   = 2'd2;

   // SYS codes
   localparam logic [2:0] SYS_NOP = 3'd0;
   localparam logic [2:0] SYS_SSI = 3'd1;
   localparam logic [2:0] SYS_SSO = 3'd2;
   localparam logic [2:0] SYS_SCL = 3'd3;
   localparam logic [2:0] SYS_SCH = 3'd4;
   localparam logic [2:0] SYS_RET = 3'd5;
   localparam logic [2:0] SYS_COR = 3'd6;
   localparam logic [2:0] SYS_OWN = 3'd7;

   // ALU codes
   localparam logic [3:0] ALU_ZERO = 4'd0;
   localparam logic [3:0] ALU_OFS  = 4'd1;
   localparam logic [3:0] ALU_NACC = 4'd2;
   localparam logic [3:0] ALU_NOFS = 4'd3;
   localparam logic [3:0] ALU_SLA  = 4'd4;
   localparam logic [3:0] ALU_SLO  = 4'd5;
   localparam logic [3:0] ALU_SRA  = 4'd6;
   localparam logic [3:0] ALU_SRO  = 4'd7;
   localparam logic [3:0] ALU_AND  = 4'd8;
   localparam logic [3:0] ALU_OR   = 4'd9;
   localparam logic [3:0] ALU_XOR  = 4'd10;
   localparam logic [3:0] ALU_ADD  = 4'd11;
   localparam logic [3:0] ALU_CRY  = 4'd12;
   localparam logic [3:0] ALU_LT   = 4'd13;
   localparam logic [3:0] ALU_EQ   = 4'd14;
   localparam logic [3:0] ALU_GT   = 4'd15;

   localparam logic [7:0] SLOT_BASE = 8'hF8;
   localparam logic [7:0] SLOT_TOP  = 8'hFF;

   function automatic logic is_reserved(input logic [7:0] op);
      logic [6:0] low;
      low = op[6:0];
      return (low == 7'h01) || (low == 7'h02) || (low == 7'h11) || (low == 7'h12) ||
             (low == 7'h21) || (low == 7'h22) || (low == 7'h33) || (low == 7'h44) ||
             (low == 7'h55);
   endfunction

endpackage

// ===== src/bcpm_alu.sv =====
module bcpm_alu (
   input  logic [7:0] op,
   input  logic [7:0] acc,
   input  logic [7:0] offset,
   output logic [7:0] alu_result,
   output logic [7:0] fix_result
);

   logic [8:0] sum;
   logic [7:0] delta;

   assign sum = {1'b0, acc} + {1'b0, offset};

   always_comb begin
      unique case (op[3:0])
         bcpm_pkg::ALU_ZERO: alu_result = 8'd0;
         bcpm_pkg::ALU_OFS:  alu_result = offset;
         bcpm_pkg::ALU_NACC: alu_result = ~acc;
         bcpm_pkg::ALU_NOFS: alu_result = ~offset;
         bcpm_pkg::ALU_SLA:  alu_result = {acc[6:0], 1'b0};
         bcpm_pkg::ALU_SLO:  alu_result = {offset[6:0], 1'b0};
         bcpm_pkg::ALU_SRA:  alu_result = {1'b0, acc[7:1]};
         bcpm_pkg::ALU_SRO:  alu_result = {1'b0, offset[7:1]};
         bcpm_pkg::ALU_AND:  alu_result = acc & offset;
         bcpm_pkg::ALU_OR:   alu_result = acc | offset;
         bcpm_pkg::ALU_XOR:  alu_result = acc ^ offset;
         bcpm_pkg::ALU_ADD:  alu_result = sum[7:0];
         bcpm_pkg::ALU_CRY:  alu_result = {7'd0, sum[8]};
         bcpm_pkg::ALU_LT:   alu_result = {8{acc < offset}};
         bcpm_pkg::ALU_EQ:   alu_result = {8{acc == offset}};
         default:            alu_result = {8{acc > offset}};
      endcase
   end

   // +4 +1 +2 +3 -4 -3 -2 -1
   always_comb begin
      unique case (op[2:0])
         3'd0:    delta = 8'd4;
         3'd1:    delta = 8'd1;
         3'd2:    delta = 8'd2;
         3'd3:    delta = 8'd3;
         3'd4:    delta = 8'd252;
         3'd5:    delta = 8'd253;
         3'd6:    delta = 8'd254;
         default: delta = 8'd255;
      endcase
   end

   assign fix_result = acc + delta;

endmodule

// ===== src/byte_cpu_pair_move_core.sv =====
// Eight-bit paged processor core around one 64 KiB single-port memory.
//
// Request channel (req_valid/req_ready/req_data): each transaction is an
// execute (one instruction), a memory byte write or a memory byte read.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one transaction
// per request, in order, carrying the data byte and the register view
// after the step.
//
// Steps, from acceptance to rsp_valid: a write is performed at pickup, a read
// adds a read-data step, and an execute runs pickup from the one-entry input
// buffer with the first memory access, decode, an optional literal, data
// or return-slot read, then the step that loads the response register.
// The single memory port sets this: every fetch, literal, data read and
// data write uses it in turn. The sequencer works on one transaction at a
// time, while the input buffer can hold the next request.
//
// Reset: the control and architectural registers clear (payload registers
// do not), then a clearing pass writes zero to all 65536 memory bytes, one per
// cycle; req_ready stays low throughout the pass. When the receiver stalls,
// the response register holds its transaction, the sequencer waits in its done
// step, and the input buffer still accepts one further request.
module byte_cpu_pair_move_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bcpm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bcpm_pkg::rsp_type   rsp_data
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_OP, ST_LIT, ST_SRC, ST_DLOAD, ST_RET, ST_RD, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // input buffer
   logic              buf_valid_ff, buf_valid_in;
   bcpm_pkg::req_type buf_ff;
   logic              buf_take;

   // work copies of the item's side inputs
   logic       sin_ff, sin_in;
   logic [7:0] pin_ff, pin_in;
   logic [7:0] op_ff, op_in;
   logic [7:0] shown_ff, shown_in;
   logic [7:0] scr_ff, scr_in;

   // architectural registers
   logic [7:0] acc_ff, acc_in, offset_ff, offset_in, inner_ff, inner_in;
   logic [7:0] pc_ff, pc_in, code_ff, code_in, dpage_ff, dpage_in;
   logic [7:0] lpage_ff, lpage_in, cpage_ff, cpage_in, enable_ff, enable_in;
   logic       sclk_ff, sclk_in, mosi_ff, mosi_in;
   logic [7:0] sin_reg_ff, sin_reg_in, sout_ff, sout_in, phold_ff, phold_in;

   logic [15:0] clr_ff, clr_in;

   // memory port
   logic [7:0]  mem [65536];
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [7:0]  mem_wdata;
   logic [7:0]  rdata_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   bcpm_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] op;
   logic [7:0] alu_result, fix_result;
   logic [7:0] pv;
   logic       pair_apply;
   logic [8:0] ofs_sum;
   logic       out_free;

   bcpm_alu u_alu (
      .op        (op),
      .acc       (acc_ff),
      .offset    (offset_ff),
      .alu_result(alu_result),
      .fix_result(fix_result)
   );

   assign op        = (state_ff == ST_OP) ? rdata_ff : op_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff != ST_CLEAR) && (!buf_valid_ff || buf_take);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign ofs_sum   = {1'b0, offset_ff} + {1'b0, pv};

   always_comb begin
      state_in     = state_ff;
      buf_take     = 1'b0;
      sin_in       = sin_ff;
      pin_in       = pin_ff;
      op_in        = op_ff;
      shown_in     = shown_ff;
      scr_in       = scr_ff;
      acc_in       = acc_ff;
      offset_in    = offset_ff;
      inner_in     = inner_ff;
      pc_in        = pc_ff;
      code_in      = code_ff;
      dpage_in     = dpage_ff;
      lpage_in     = lpage_ff;
      cpage_in     = cpage_ff;
      enable_in    = enable_ff;
      sclk_in      = sclk_ff;
      mosi_in      = mosi_ff;
      sin_reg_in   = sin_reg_ff;
      sout_in      = sout_ff;
      phold_in     = phold_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_addr     = {code_ff, pc_ff};
      mem_wdata    = 8'd0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pv           = rdata_ff;
      pair_apply   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 16'd1;
            if (clr_ff == 16'hFFFF) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (buf_valid_ff) begin
               buf_take = 1'b1;
               sin_in   = buf_ff.serial_in_bit;
               pin_in   = buf_ff.parallel_in;
               scr_in   = 8'd0;
               unique case (buf_ff.kind)
                  bcpm_pkg::KIND_EXEC: begin
                     pc_in    = pc_ff + 8'd1;
                     state_in = ST_OP;
                  end
                  bcpm_pkg::KIND_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = buf_ff.mem_address;
                     mem_wdata = buf_ff.mem_data;
                     shown_in  = buf_ff.mem_data;
                     state_in  = ST_DONE;
                  end
                  bcpm_pkg::KIND_READ: begin
                     mem_addr = buf_ff.mem_address;
                     state_in = ST_RD;
                  end
                  default: begin
                     shown_in = 8'd0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD: begin
            shown_in = rdata_ff;
            state_in = ST_DONE;
         end
         ST_OP: begin
            op_in    = rdata_ff;
            shown_in = rdata_ff;
            state_in = ST_DONE;
            priority if (op[7]) begin
               if (bcpm_pkg::is_reserved(op)) begin
                  scr_in = op;
               end else if (op[6:4] == bcpm_pkg::SRC_LIT) begin
                  mem_addr = {code_ff, pc_ff};
                  pc_in    = pc_ff + 8'd1;
                  state_in = ST_LIT;
               end else if (op[6:4] == bcpm_pkg::SRC_DMEM) begin
                  mem_addr = {dpage_ff, offset_ff};
                  state_in = ST_SRC;
               end else if (op[6:4] == bcpm_pkg::SRC_LMEM) begin
                  mem_addr = {lpage_ff, offset_ff};
                  state_in = ST_SRC;
               end else begin
                  pair_apply = 1'b1;
                  unique case (op[6:4])
                     bcpm_pkg::SRC_DPAGE: pv = dpage_ff;
                     bcpm_pkg::SRC_ACC:   pv = acc_ff;
                     bcpm_pkg::SRC_INNER: pv = inner_ff;
                     bcpm_pkg::SRC_SIN:   pv = sin_reg_ff;
                     default:             pv = pin_ff;
                  endcase
               end
            end else if (op[6]) begin
               mem_addr = {lpage_ff, bcpm_pkg::SLOT_BASE | {5'd0, op[2:0]}};
               if (op[3]) begin
                  mem_we = 1'b1;
                  unique case (op[5:4])
                     bcpm_pkg::DR_DPAGE: mem_wdata = dpage_ff;
                     bcpm_pkg::DR_INNER: mem_wdata = inner_ff;
                     bcpm_pkg::DR_ACC:   mem_wdata = acc_ff;
                     default:            mem_wdata = offset_ff;
                  endcase
               end else begin
                  state_in = ST_DLOAD;
               end
            end else if (op[5]) begin
               inner_in = pc_in;
               cpage_in = code_ff;
               lpage_in = lpage_ff - 8'd1;
               pc_in    = 8'd0;
               code_in  = {3'd0, op[4:0]};
            end else if (op[4]) begin
               acc_in = alu_result;
            end else if (op[3]) begin
               acc_in = fix_result;
            end else begin
               unique case (op[2:0])
                  bcpm_pkg::SYS_NOP: ;
                  bcpm_pkg::SYS_SSI: sin_reg_in = {sin_reg_ff[6:0], sin_ff};
                  bcpm_pkg::SYS_SSO: begin
                     mosi_in = sout_ff[7];
                     sout_in = {sout_ff[6:0], 1'b0};
                  end
                  bcpm_pkg::SYS_SCL: sclk_in = 1'b0;
                  bcpm_pkg::SYS_SCH: sclk_in = 1'b1;
                  bcpm_pkg::SYS_RET: begin
                     mem_addr = {lpage_ff, bcpm_pkg::SLOT_TOP};
                     state_in = ST_RET;
                  end
                  bcpm_pkg::SYS_COR: begin
                     code_in = dpage_ff;
                     pc_in   = inner_ff;
                  end
                  default: begin
                     mem_we    = 1'b1;
                     mem_addr  = {lpage_ff, bcpm_pkg::SLOT_TOP};
                     mem_wdata = cpage_ff;
                  end
               endcase
            end
         end
         ST_LIT, ST_SRC: begin
            pair_apply = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DLOAD: begin
            unique case (op[5:4])
               bcpm_pkg::DR_DPAGE: dpage_in  = rdata_ff;
               bcpm_pkg::DR_INNER: inner_in  = rdata_ff;
               bcpm_pkg::DR_ACC:   acc_in    = rdata_ff;
               default:            offset_in = rdata_ff;
            endcase
            state_in = ST_DONE;
         end
         ST_RET: begin
            code_in  = rdata_ff;
            pc_in    = inner_ff;
            lpage_in = lpage_ff + 8'd1;
            state_in = ST_DONE;
         end
         default: begin
            // done: load the response once the output register is free
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.data_out       = shown_ff;
               rsp_in.code_address   = {code_ff, pc_ff};
               rsp_in.acc_out        = acc_ff;
               rsp_in.offset_out     = offset_ff;
               rsp_in.data_page_out  = dpage_ff;
               rsp_in.inner_out      = inner_ff;
               rsp_in.local_page_out = lpage_ff;
               rsp_in.sclk_out       = sclk_ff;
               rsp_in.mosi_out       = mosi_ff;
               rsp_in.parallel_out   = phold_ff;
               rsp_in.enable_out     = enable_ff;
               rsp_in.scrounge_out   = scr_ff;
               state_in              = ST_IDLE;
            end
         end
      endcase

      // PAIR destination update with value pv
      if (pair_apply) begin
         unique case (op[3:0])
            bcpm_pkg::DST_OFFSET: offset_in = pv;
            bcpm_pkg::DST_DMEM: begin
               mem_we    = 1'b1;
               mem_addr  = {dpage_ff, offset_ff};
               mem_wdata = pv;
            end
            bcpm_pkg::DST_LMEM: begin
               mem_we    = 1'b1;
               mem_addr  = {lpage_ff, offset_ff};
               mem_wdata = pv;
            end
            bcpm_pkg::DST_DPAGE:  dpage_in  = pv;
            bcpm_pkg::DST_ACC:    acc_in    = pv;
            bcpm_pkg::DST_INNER:  inner_in  = pv;
            bcpm_pkg::DST_SOUT:   sout_in   = pv;
            bcpm_pkg::DST_POUT:   phold_in  = pv;
            bcpm_pkg::DST_ENABLE: enable_in = pv;
            bcpm_pkg::DST_ADDOFS: begin
               offset_in = ofs_sum[7:0];
               if (ofs_sum[8]) begin
                  dpage_in = dpage_ff + 8'd1;
               end
            end
            bcpm_pkg::DST_JREL: pc_in = pc_ff + pv;
            bcpm_pkg::DST_JMP:  pc_in = pv;
            bcpm_pkg::DST_LOOP: begin
               if (inner_ff != 8'd0) begin
                  pc_in = pv;
               end
               inner_in = inner_ff - 8'd1;
            end
            bcpm_pkg::DST_JNZ: begin
               if (acc_ff != 8'd0) begin
                  pc_in = pv;
               end
            end
            bcpm_pkg::DST_JZ: begin
               if (acc_ff == 8'd0) begin
                  pc_in = pv;
               end
            end
            default: begin
               inner_in = pc_ff;
               cpage_in = code_ff;
               lpage_in = lpage_ff - 8'd1;
               pc_in    = 8'd0;
               code_in  = pv;
            end
         endcase
      end
   end

   assign buf_valid_in = (req_valid && req_ready) || (buf_valid_ff && !buf_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= 16'd0;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         offset_ff    <= 8'd0;
         inner_ff     <= 8'd0;
         pc_ff        <= 8'd0;
         code_ff      <= 8'd0;
         dpage_ff     <= 8'd0;
         lpage_ff     <= 8'd0;
         cpage_ff     <= 8'd0;
         enable_ff    <= 8'd0;
         sclk_ff      <= 1'b0;
         mosi_ff      <= 1'b0;
         sin_reg_ff   <= 8'd0;
         sout_ff      <= 8'd0;
         phold_ff     <= 8'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         offset_ff    <= offset_in;
         inner_ff     <= inner_in;
         pc_ff        <= pc_in;
         code_ff      <= code_in;
         dpage_ff     <= dpage_in;
         lpage_ff     <= lpage_in;
         cpage_ff     <= cpage_in;
         enable_ff    <= enable_in;
         sclk_ff      <= sclk_in;
         mosi_ff      <= mosi_in;
         sin_reg_ff   <= sin_reg_in;
         sout_ff      <= sout_in;
         phold_ff     <= phold_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         buf_ff <= req_data;
      end
      sin_ff   <= sin_in;
      pin_ff   <= pin_in;
      op_ff    <= op_in;
      shown_ff <= shown_in;
      scr_ff   <= scr_in;
      rsp_ff   <= rsp_in;
   end

   // single-port memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   // no request enters during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during memory clear");

   // a finished step with a free output register publishes next cycle
   a_done_publishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished step did not publish");

   // opcode decode only follows the pickup of an item
   a_op_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OP) |-> ($past(state_ff) == ST_IDLE))
      else $error("decode without fetch");

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_ff))
      else $error("stalled response changed");

endmodule
